/* rtl/dcst_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deferred-call slot table package
// Widths, action and status codes, controller states and the command and
// status structs shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package dcst_pkg;

  // Default table depth
  localparam int unsigned SLOT_COUNT_DEF = 16;

  // Beat field widths
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned DATA_W   = 32;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_INSERT  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_PROCESS = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } dcst_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_req;  // capture the request beat, rewind the scan
    logic scan;      // scan pointer is live this cycle
    logic advance;   // step the scan pointer
    logic commit;    // update the table and load the result register
  } dcst_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_valid;    // request beat offered
    logic needs_scan;  // offered request is insert or process
    logic hit;         // current slot matches the search
    logic last;        // scan pointer sits on the final slot
    logic out_free;    // result register can take a new beat
  } dcst_sts_t;

endpackage
`default_nettype wire

/* rtl/dcst_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one table request per beat.
// ----------------------------------------------------------------------------
interface dcst_in_if;

  logic                                valid;
  logic                                ready;
  logic [dcst_pkg::ACTION_W-1:0]       action;
  logic [dcst_pkg::DATA_W-1:0]         handler_addr;
  logic [dcst_pkg::DATA_W-1:0]         context_word;
  logic [dcst_pkg::SLOT_W-1:0]         slot_index;

  modport source (
    output valid, action, handler_addr, context_word, slot_index,
    input  ready
  );

  modport sink (
    input  valid, action, handler_addr, context_word, slot_index,
    output ready
  );

endinterface
`default_nettype wire

/* rtl/dcst_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one table result per beat.
// ----------------------------------------------------------------------------
interface dcst_out_if;

  logic                                valid;
  logic                                ready;
  logic [dcst_pkg::STATUS_W-1:0]       status;
  logic [dcst_pkg::SLOT_W-1:0]         slot_used;
  logic [dcst_pkg::DATA_W-1:0]         out_handler;
  logic [dcst_pkg::DATA_W-1:0]         out_context;

  modport source (
    output valid, status, slot_used, out_handler, out_context,
    input  ready
  );

  modport sink (
    input  valid, status, slot_used, out_handler, out_context,
    output ready
  );

endinterface
`default_nettype wire

/* rtl/dcst_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slot table controller
// Sequences one request: capture, a slot scan for insert and process, then
// commit once the result register is free.
// ----------------------------------------------------------------------------
module dcst_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dcst_pkg::dcst_sts_t sts_i,
  output dcst_pkg::dcst_cmd_t    cmd_o,
  output logic                   in_ready_o
);

  dcst_pkg::dcst_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dcst_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dcst_pkg::ST_IDLE: begin
        if (sts_i.in_valid) begin
          state_d = sts_i.needs_scan ? dcst_pkg::ST_SCAN : dcst_pkg::ST_FIN;
        end
      end
      dcst_pkg::ST_SCAN: begin
        if (sts_i.hit || sts_i.last) begin
          state_d = dcst_pkg::ST_FIN;
        end
      end
      dcst_pkg::ST_FIN: begin
        if (sts_i.out_free) begin
          state_d = dcst_pkg::ST_IDLE;
        end
      end
      default: state_d = dcst_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      dcst_pkg::ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load_req = sts_i.in_valid;
      end
      dcst_pkg::ST_SCAN: begin
        cmd_o.scan    = 1'b1;
        cmd_o.advance = !sts_i.hit && !sts_i.last;
      end
      dcst_pkg::ST_FIN: begin
        cmd_o.commit = sts_i.out_free;
      end
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/dcst_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slot table datapath
// Request register, occupancy flags, handler/context memory, scan pointer
// and the result register.
// ----------------------------------------------------------------------------
module dcst_dp #(
  parameter int unsigned SLOT_COUNT = dcst_pkg::SLOT_COUNT_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire dcst_pkg::dcst_cmd_t           cmd_i,
  output dcst_pkg::dcst_sts_t                sts_o,
  // request beat
  input  wire logic                          in_valid_i,
  input  wire logic [dcst_pkg::ACTION_W-1:0] in_action_i,
  input  wire logic [dcst_pkg::DATA_W-1:0]   in_handler_i,
  input  wire logic [dcst_pkg::DATA_W-1:0]   in_context_i,
  input  wire logic [dcst_pkg::SLOT_W-1:0]   in_index_i,
  // result beat
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [dcst_pkg::STATUS_W-1:0]      out_status_o,
  output logic [dcst_pkg::SLOT_W-1:0]        out_slot_o,
  output logic [dcst_pkg::DATA_W-1:0]        out_handler_o,
  output logic [dcst_pkg::DATA_W-1:0]        out_context_o
);

  localparam int unsigned IDX_W   = $clog2(SLOT_COUNT);
  localparam int unsigned ENTRY_W = 2 * dcst_pkg::DATA_W;

  // Request register
  logic [dcst_pkg::ACTION_W-1:0] req_action_q;
  logic [dcst_pkg::DATA_W-1:0]   req_handler_q;
  logic [dcst_pkg::DATA_W-1:0]   req_context_q;
  logic [dcst_pkg::SLOT_W-1:0]   req_index_q;

  // Scan state
  logic [IDX_W-1:0]      cnt_q;
  logic                  found_q;
  logic [SLOT_COUNT-1:0] occ_q, occ_d;

  // Slot memory and its registered read port
  logic [ENTRY_W-1:0] slot_mem [SLOT_COUNT];
  logic [ENTRY_W-1:0] rd_q;

  // Result register
  logic                          out_valid_q, out_valid_d;
  logic [dcst_pkg::STATUS_W-1:0] out_status_q, out_status_d;
  logic [dcst_pkg::SLOT_W-1:0]   out_slot_q, out_slot_d;
  logic [dcst_pkg::DATA_W-1:0]   out_handler_q, out_handler_d;
  logic [dcst_pkg::DATA_W-1:0]   out_context_q, out_context_d;

  logic             occ_bit;
  logic             hit;
  logic             rm_in_range;
  logic [IDX_W-1:0] rm_idx;
  logic             mem_we;

  // Search condition on the current slot
  assign occ_bit = occ_q[cnt_q];
  always_comb begin
    case (req_action_q)
      dcst_pkg::ACT_INSERT:  hit = !occ_bit;
      dcst_pkg::ACT_PROCESS: hit = occ_bit;
      default:               hit = 1'b0;
    endcase
  end

  assign rm_in_range = 32'(req_index_q) < SLOT_COUNT;
  assign rm_idx      = IDX_W'(req_index_q);
  assign mem_we      = cmd_i.commit && found_q && (req_action_q == dcst_pkg::ACT_INSERT);

  // Status towards the controller
  always_comb begin
    sts_o.in_valid   = in_valid_i;
    sts_o.needs_scan = (in_action_i == dcst_pkg::ACT_INSERT) ||
                       (in_action_i == dcst_pkg::ACT_PROCESS);
    sts_o.hit        = hit;
    sts_o.last       = (cnt_q == IDX_W'(SLOT_COUNT - 1));
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  // Capture the request beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_action_q  <= in_action_i;
      req_handler_q <= in_handler_i;
      req_context_q <= in_context_i;
      req_index_q   <= in_index_i;
    end
  end

  // Scan pointer and match flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      found_q <= 1'b0;
    end else if (cmd_i.load_req) begin
      cnt_q   <= '0;
      found_q <= 1'b0;
    end else begin
      if (cmd_i.advance) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.scan && hit) begin
        found_q <= 1'b1;
      end
    end
  end

  // Occupancy update on commit
  always_comb begin
    occ_d = occ_q;
    if (cmd_i.commit) begin
      case (req_action_q)
        dcst_pkg::ACT_INSERT: begin
          if (found_q) occ_d[cnt_q] = (req_handler_q != '0);
        end
        dcst_pkg::ACT_PROCESS: begin
          if (found_q) occ_d[cnt_q] = 1'b0;
        end
        dcst_pkg::ACT_REMOVE: begin
          if (rm_in_range) occ_d[rm_idx] = 1'b0;
        end
        default: occ_d = occ_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // Slot memory: write on insert commit, read at the scan pointer
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[cnt_q] <= {req_handler_q, req_context_q};
    end
    rd_q <= slot_mem[cnt_q];
  end

  // Build the result beat
  always_comb begin
    out_status_d  = dcst_pkg::STATUS_DONE;
    out_slot_d    = '0;
    out_handler_d = '0;
    out_context_d = '0;
    case (req_action_q)
      dcst_pkg::ACT_INSERT: begin
        if (found_q) begin
          out_slot_d = dcst_pkg::SLOT_W'(cnt_q);
        end else begin
          out_status_d = dcst_pkg::STATUS_FULL;
        end
      end
      dcst_pkg::ACT_PROCESS: begin
        if (found_q) begin
          out_slot_d    = dcst_pkg::SLOT_W'(cnt_q);
          out_handler_d = rd_q[ENTRY_W-1:dcst_pkg::DATA_W];
          out_context_d = rd_q[dcst_pkg::DATA_W-1:0];
        end else begin
          out_status_d = dcst_pkg::STATUS_EMPTY;
        end
      end
      default: out_status_d = dcst_pkg::STATUS_DONE;
    endcase
  end

  // Result valid: set on commit, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the result payload until the next commit
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_status_q  <= out_status_d;
      out_slot_q    <= out_slot_d;
      out_handler_q <= out_handler_d;
      out_context_q <= out_context_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_status_o  = out_status_q;
  assign out_slot_o    = out_slot_q;
  assign out_handler_o = out_handler_q;
  assign out_context_o = out_context_q;

endmodule
`default_nettype wire

/* rtl/deferred_call_slot_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deferred-call slot table
// Fixed table of handler/context slots with insert, remove and process.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  --------+-----+----------------------------------------------------------
//  in_i    | in  | action, handler_addr, context_word, slot_index
//  out_o   | out | status, slot_used, out_handler, out_context
//
//  Insert and process: beat, a scan of 1 .. SLOT_COUNT slots (one a cycle),
//  then commit; remove and the unused action go straight from the beat to
//  commit. The result beat follows commit.
//  One request is in flight. Reset clears the occupancy flags at once.
//  A stalled result holds in the output register; the next request is taken
//  meanwhile and waits at commit until the register frees.
// ----------------------------------------------------------------------------
module deferred_call_slot_table #(
  parameter int unsigned SLOT_COUNT = dcst_pkg::SLOT_COUNT_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  dcst_in_if.sink     in_i,
  dcst_out_if.source  out_o
);

  dcst_pkg::dcst_cmd_t cmd;
  dcst_pkg::dcst_sts_t sts;

  // Sequencer
  dcst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_i.ready)
  );

  // Table storage and result register
  dcst_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_valid_i    (in_i.valid),
    .in_action_i   (in_i.action),
    .in_handler_i  (in_i.handler_addr),
    .in_context_i  (in_i.context_word),
    .in_index_i    (in_i.slot_index),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_status_o  (out_o.status),
    .out_slot_o    (out_o.slot_used),
    .out_handler_o (out_o.out_handler),
    .out_context_o (out_o.out_context)
  );

endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deferred-call slot table testbench
// Drives request beats through the valid/ready request channel, keeps its own
// copy of the handler and context table to work out each result, and checks
// every result beat in order. Covers the edge cases directly first: empty and
// full tables, zero handlers, removes and the unused action. It then runs
// fill/drain bursts and a random mix, and ends with a long result stall that
// backs up the request channel.
// ----------------------------------------------------------------------------
module tb;
  import dcst_pkg::*;

  localparam int unsigned SLOTS          = 16;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned LONG_STALL     = 300;

  // Action code with no defined operation
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [DATA_W-1:0]   handler;
    logic [DATA_W-1:0]   ctx;
    logic [SLOT_W-1:0]   slot;
  } table_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [DATA_W-1:0]   handler;
    logic [DATA_W-1:0]   ctx;
  } table_res_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  dcst_in_if  req_if ();
  dcst_out_if res_if ();

  deferred_call_slot_table #(
    .SLOT_COUNT(SLOTS)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  // Shadow table and the results still owed by the block
  logic [DATA_W-1:0] handler_tbl [SLOTS];
  logic [DATA_W-1:0] context_tbl [SLOTS];
  table_res_t        pending_results [$];

  int fail_cnt     = 0;
  bit src_idle_en  = 1'b0;
  bit sink_idle_en = 1'b0;
  int stall_req    = 0;
  int stall_left   = 0;

  // Clock: 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Apply one request to the shadow table and return the result it yields
  function automatic table_res_t apply_request(table_req_t r);
    table_res_t res;
    bit         found;
    res    = '0;
    found  = 1'b0;
    res.status = STATUS_DONE;
    case (r.action)
      ACT_INSERT: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!found && handler_tbl[i] == '0) begin
            handler_tbl[i] = r.handler;
            context_tbl[i] = r.ctx;
            res.slot       = SLOT_W'(i);
            found          = 1'b1;
          end
        end
        if (!found) res.status = STATUS_FULL;
      end
      ACT_REMOVE: begin
        if (r.slot < SLOTS) begin
          handler_tbl[r.slot] = '0;
          context_tbl[r.slot] = '0;
        end
      end
      ACT_PROCESS: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!found && handler_tbl[i] != '0) begin
            res.slot       = SLOT_W'(i);
            res.handler    = handler_tbl[i];
            res.ctx        = context_tbl[i];
            handler_tbl[i] = '0;
            context_tbl[i] = '0;
            found          = 1'b1;
          end
        end
        if (!found) res.status = STATUS_EMPTY;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic table_req_t make_req(logic [ACTION_W-1:0] action,
                                          logic [DATA_W-1:0] handler,
                                          logic [DATA_W-1:0] ctx,
                                          logic [SLOT_W-1:0] slot);
    table_req_t r;
    r.action  = action;
    r.handler = handler;
    r.ctx     = ctx;
    r.slot    = slot;
    return r;
  endfunction

  // Random request; percentages pick insert, process and remove, rest unused
  function automatic table_req_t random_req(int ins_pct, int proc_pct, int rem_pct);
    table_req_t r;
    int         roll;
    roll      = $urandom_range(99);
    r.handler = ($urandom_range(15) == 0) ? '0 : DATA_W'($urandom);
    r.ctx     = DATA_W'($urandom);
    r.slot    = SLOT_W'($urandom_range(SLOTS - 1));
    if (roll < ins_pct)                           r.action = ACT_INSERT;
    else if (roll < ins_pct + proc_pct)           r.action = ACT_PROCESS;
    else if (roll < ins_pct + proc_pct + rem_pct) r.action = ACT_REMOVE;
    else                                          r.action = ACT_UNUSED;
    return r;
  endfunction

  // Drop valid for one cycle with junk on the payload
  task automatic idle_line();
    req_if.valid        <= 1'b0;
    req_if.action       <= ACTION_W'($urandom);
    req_if.handler_addr <= DATA_W'($urandom);
    req_if.context_word <= DATA_W'($urandom);
    req_if.slot_index   <= SLOT_W'($urandom);
    @(posedge clk_i);
  endtask

  // Offer one beat, hold it until taken, then book its expected result
  task automatic send_request(table_req_t r);
    while (src_idle_en && $urandom_range(99) < 13) idle_line();
    req_if.valid        <= 1'b1;
    req_if.action       <= r.action;
    req_if.handler_addr <= r.handler;
    req_if.context_word <= r.ctx;
    req_if.slot_index   <= r.slot;
    do @(posedge clk_i); while (!req_if.ready);
    pending_results.push_back(apply_request(r));
  endtask

  // Result ready: random idling, plus a long hold-off when requested
  always @(posedge clk_i) begin
    if (stall_req > 0) begin
      stall_left = stall_req;
      stall_req  = 0;
    end
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      res_if.ready <= 1'b0;
      stall_left--;
    end else begin
      res_if.ready <= !(sink_idle_en && $urandom_range(99) < 13);
    end
  end

  task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endtask

  // Compare each result beat against the oldest expectation
  always @(posedge clk_i) begin
    table_res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: status %0h slot %0h",
               res_if.status, res_if.slot_used);
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", DATA_W'(want.status), DATA_W'(res_if.status));
        check_field("slot_used", DATA_W'(want.slot), DATA_W'(res_if.slot_used));
        check_field("out_handler", want.handler, res_if.out_handler);
        check_field("out_context", want.ctx, res_if.out_context);
      end
    end
  end

  // Watchdog: end the run if no beat moves on either channel for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("[deferred_call_slot_table] ERROR");
    $finish;
  end

  // Edge cases: empty, zero handler, removes, unused action, full table
  task automatic test_directed();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    send_request(make_req(ACT_PROCESS, '1, '1, '1));
    send_request(make_req(ACT_INSERT, '1, '1, '0));
    send_request(make_req(ACT_INSERT, '0, 32'h1234_5678, '1));
    send_request(make_req(ACT_INSERT, 32'h0000_0001, '0, '0));
    send_request(make_req(ACT_REMOVE, '0, '0, 4'hf));
    send_request(make_req(ACT_REMOVE, '1, '1, 4'h0));
    send_request(make_req(ACT_UNUSED, '1, '1, '1));
    send_request(make_req(ACT_PROCESS, '0, '0, '0));
    // Fill every slot, then overflow
    for (int i = 0; i < SLOTS; i++) begin
      send_request(make_req(ACT_INSERT, DATA_W'($urandom) | 32'h1, DATA_W'($urandom),
                            SLOT_W'($urandom)));
    end
    send_request(make_req(ACT_INSERT, 32'hdead_beef, 32'hcafe_f00d, '0));
    send_request(make_req(ACT_REMOVE, '0, '0, 4'h7));
    send_request(make_req(ACT_PROCESS, '0, '0, '0));
    idle_line();
  endtask

  // Alternate insert-heavy and process-heavy bursts to hit full and empty often
  task automatic test_fill_drain();
    for (int round = 0; round < 3; round++) begin
      for (int n = 0; n < 20; n++) send_request(random_req(85, 5, 5));
      for (int n = 0; n < 20; n++) send_request(random_req(5, 80, 10));
    end
    idle_line();
  endtask

  // Balanced random mix, opening with a stretch free of idling on both sides
  task automatic test_random_mix();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    for (int n = 0; n < 80; n++) send_request(random_req(45, 30, 20));
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    for (int n = 0; n < 170; n++) send_request(random_req(42, 33, 20));
    idle_line();
  endtask

  // Hold off results for a long stretch while requests keep coming
  task automatic test_backpressure();
    src_idle_en = 1'b0;
    stall_req   = LONG_STALL;
    for (int n = 0; n < 24; n++) send_request(random_req(50, 40, 8));
    src_idle_en = 1'b1;
    idle_line();
  endtask

  initial begin
    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.action       = ACT_INSERT;
    req_if.handler_addr = '0;
    req_if.context_word = '0;
    req_if.slot_index   = '0;
    res_if.ready        = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      handler_tbl[i] = '0;
      context_tbl[i] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_fill_drain();
    test_random_mix();
    test_backpressure();

    // Drain the outstanding results, then watch for strays
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("[deferred_call_slot_table] OK");
    end else begin
      $display("[deferred_call_slot_table] ERROR");
    end
    $finish;
  end

endmodule
